/* sv/stuck_actuator_pin_guard_core_macros.svh */
// Assertion helpers, sampled on clk and disabled during reset.
`ifndef STUCK_ACTUATOR_PIN_GUARD_CORE_MACROS_SVH
`define STUCK_ACTUATOR_PIN_GUARD_CORE_MACROS_SVH

// Same-cycle implication.
`define SAPG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sapg assertion failed");

// Next-cycle implication.
`define SAPG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sapg assertion failed");

`endif

/* sv/sapg_pkg.sv */
package sapg_pkg;

  localparam int PIN_COUNT = 1024;
  localparam int PIN_AW    = $clog2(PIN_COUNT);
  localparam int CFG_IDX_W = 3;

  localparam logic [7:0] HEIGHT_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAFETY_ENABLE = 3'd0,
    CFG_DISC_THRESH   = 3'd1,
    CFG_OFF_DELAY     = 3'd2,
    CFG_ON_DELAY      = 3'd3,
    CFG_LOW_CLIP      = 3'd4,
    CFG_HIGH_CLIP     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0]  pin_index;
    logic [7:0]  commanded_height;
    logic [7:0]  measured_height;
    logic [31:0] now_ms;
    logic        invert;
  } in_item_t;

  typedef struct packed {
    logic [7:0] drive_height;
    logic       pin_active;
    logic [7:0] discrepancy;
  } out_item_t;

  typedef struct packed {
    logic        safety_enable;
    logic [7:0]  discrepancy_threshold;
    logic [31:0] off_delay_ms;
    logic [31:0] on_delay_ms;
    logic [7:0]  low_clip;
    logic [7:0]  high_clip;
  } cfg_t;

  typedef struct packed {
    logic        enabled;
    logic [31:0] since;
  } pin_state_t;

  typedef struct packed {
    logic              en;
    logic [PIN_AW-1:0] addr;
    pin_state_t        data;
  } wr_req_t;

endpackage

/* sv/sapg_cfg.sv */
module sapg_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [sapg_pkg::CFG_IDX_W-1:0]   wr_idx,
  input  logic [31:0]                      wr_data,
  output sapg_pkg::cfg_t                   cfg
);
  import sapg_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        CFG_SAFETY_ENABLE: cfg_nxt.safety_enable         = wr_data[0];
        CFG_DISC_THRESH:   cfg_nxt.discrepancy_threshold = wr_data[7:0];
        CFG_OFF_DELAY:     cfg_nxt.off_delay_ms          = wr_data;
        CFG_ON_DELAY:      cfg_nxt.on_delay_ms           = wr_data;
        CFG_LOW_CLIP:      cfg_nxt.low_clip              = wr_data[7:0];
        CFG_HIGH_CLIP:     cfg_nxt.high_clip             = wr_data[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.safety_enable         <= 1'b1;
      cfg_r.discrepancy_threshold <= 8'd100;
      cfg_r.off_delay_ms          <= 32'd1000;
      cfg_r.on_delay_ms           <= 32'd3000;
      cfg_r.low_clip              <= 8'd0;
      cfg_r.high_clip             <= 8'd255;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/sapg_store.sv */
module sapg_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [sapg_pkg::PIN_AW-1:0]   rd_addr,
  output sapg_pkg::pin_state_t          rd_data,
  input  sapg_pkg::wr_req_t             wr,
  output logic                          busy
);
  import sapg_pkg::*;

  pin_state_t        mem [PIN_COUNT];
  pin_state_t        rd_q_r;
  logic [PIN_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              clr_busy_r, clr_busy_nxt;
  logic              we;
  logic [PIN_AW-1:0] wa;
  pin_state_t        wd;

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == PIN_AW'(PIN_COUNT - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  // sweep reset values in before any transaction is taken
  always_comb begin
    if (clr_busy_r) begin
      we         = 1'b1;
      wa         = clr_cnt_r;
      wd.enabled = 1'b1;
      wd.since   = '0;
    end else begin
      we = wr.en;
      wa = wr.addr;
      wd = wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_q_r;
  assign busy    = clr_busy_r;

endmodule

/* sv/stuck_actuator_pin_guard_core.sv */
// Stuck actuator pin guard: one result transaction per input transaction, sustained at one
// per clock unless out_ready stalls the output or the memory clear is running. The pin
// memory is read at the edge that accepts the input; the input is held in the s1 stage
// register, and the updated result is loaded into the output register when that register
// is empty or being taken, which raises out_valid. The per-pin state lives in one memory
// with one read and one write port, and a write to the pin just read is forwarded. After
// reset the block clears its 1024-entry pin memory, one entry per cycle, holding in_ready
// low until the clear is done; configuration writes are taken at any time.
`include "stuck_actuator_pin_guard_core_macros.svh"

module stuck_actuator_pin_guard_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sapg_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sapg_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sapg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import sapg_pkg::*;

  cfg_t       cfg;
  pin_state_t rd_data;
  wr_req_t    wr;
  logic       busy;
  logic       in_acc;
  logic       s1_adv;

  logic       s1_v_r, s1_v_nxt;
  logic       s1_fwd_r, s1_fwd_nxt;
  in_item_t   s1_in_r;
  pin_state_t fwd_r;
  logic       out_v_r, out_v_nxt;
  out_item_t  out_r;

  pin_state_t cur;
  pin_state_t upd;
  out_item_t  res;
  logic       idx_ok;
  logic [7:0] disc;
  logic [7:0] h;
  logic       active;
  logic [31:0] elapsed;

  assign cfg_ready = 1'b1;

  sapg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  sapg_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_data.pin_index[PIN_AW-1:0]),
    .rd_data (rd_data),
    .wr      (wr),
    .busy    (busy)
  );

  assign s1_adv   = !out_v_r || out_ready;
  assign in_ready = !busy && (!s1_v_r || s1_adv);
  assign in_acc   = in_valid && in_ready;

  assign cur     = s1_fwd_r ? fwd_r : rd_data;
  assign idx_ok  = 32'(s1_in_r.pin_index) < 32'(PIN_COUNT);
  assign elapsed = s1_in_r.now_ms - cur.since;

  always_comb begin
    disc   = (s1_in_r.commanded_height >= s1_in_r.measured_height) ?
             (s1_in_r.commanded_height - s1_in_r.measured_height) :
             (s1_in_r.measured_height - s1_in_r.commanded_height);
    h      = s1_in_r.commanded_height;
    active = 1'b1;
    upd    = cur;
    if (idx_ok) begin
      active = cur.enabled;
      if (cfg.safety_enable) begin
        if (cur.enabled) begin
          if (disc < cfg.discrepancy_threshold) begin
            upd.since = s1_in_r.now_ms;
          end else if (elapsed > cfg.off_delay_ms) begin
            active = 1'b0;
          end
        end else begin
          if (elapsed > cfg.on_delay_ms) begin
            active    = 1'b1;
            upd.since = s1_in_r.now_ms;
          end else begin
            h = s1_in_r.measured_height;
          end
        end
        upd.enabled = active;
      end
    end
    if (h <= cfg.low_clip) begin
      h = cfg.low_clip;
    end else if (h >= cfg.high_clip) begin
      h = cfg.high_clip;
    end
    if (s1_in_r.invert) begin
      h = HEIGHT_MAX - h;
    end
    res.drive_height = h;
    res.pin_active   = active;
    res.discrepancy  = disc;
  end

  assign wr.en   = s1_v_r && s1_adv && idx_ok && cfg.safety_enable;
  assign wr.addr = s1_in_r.pin_index[PIN_AW-1:0];
  assign wr.data = upd;

  always_comb begin
    s1_v_nxt   = s1_v_r;
    s1_fwd_nxt = s1_fwd_r;
    if (in_acc) begin
      s1_v_nxt   = 1'b1;
      s1_fwd_nxt = wr.en && (wr.addr == in_data.pin_index[PIN_AW-1:0]);
    end else if (s1_adv) begin
      s1_v_nxt   = 1'b0;
      s1_fwd_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_v_r && s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s1_fwd_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      s1_v_r   <= s1_v_nxt;
      s1_fwd_r <= s1_fwd_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_in_r <= in_data;
    end
    if (wr.en) begin
      fwd_r <= wr.data;
    end
    if (s1_v_r && s1_adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `SAPG_ASSERT_IMP(a_clear_blocks_input, busy, !in_ready && !s1_v_r)
  `SAPG_ASSERT_IMP(a_no_write_in_clear, busy, !wr.en)
  `SAPG_ASSERT_IMP(a_fwd_needs_item, s1_fwd_r, s1_v_r)
  `SAPG_ASSERT_NXT(a_stall_holds_s1, s1_v_r && !s1_adv, s1_v_r && $stable(s1_in_r))

endmodule
